### rtl/kvp_pkg.sv
// Shared types and constants of the key/value record stream parser.
// No dependencies; used by every module under rtl/.
package kvp_pkg;

	localparam int LEN_WIDTH_DEF = 16;
	localparam int CFG_WIDTH     = 16;

	// register indexes of the configuration port
	localparam logic REG_MAX_KEY_LEN  = 1'b0;
	localparam logic REG_MAX_DATA_LEN = 1'b1;

	// framing characters
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] DEC_BASE = 8'd10;

	// result kinds
	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_KEY   = 3'd1;
	localparam logic [2:0] KIND_DATA  = 3'd2;
	localparam logic [2:0] KIND_DONE  = 3'd3;
	localparam logic [2:0] KIND_ERROR = 3'd4;

	// error codes
	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NO_PLUS   = 4'd1;
	localparam logic [3:0] ERR_KEY_LEN   = 4'd2;
	localparam logic [3:0] ERR_ZERO_KEY  = 4'd3;
	localparam logic [3:0] ERR_DATA_LEN  = 4'd4;
	localparam logic [3:0] ERR_NO_ARROW  = 4'd5;
	localparam logic [3:0] ERR_LINE_END  = 4'd6;
	localparam logic [3:0] ERR_TRUNCATED = 4'd7;
	localparam logic [3:0] ERR_OVER_MAX  = 4'd8;

	typedef enum logic [7:0] {
		PH_PLUS    = 8'b0000_0001,
		PH_KEYLEN  = 8'b0000_0010,
		PH_DATALEN = 8'b0000_0100,
		PH_KEY     = 8'b0000_1000,
		PH_ARROW1  = 8'b0001_0000,
		PH_ARROW2  = 8'b0010_0000,
		PH_DATA    = 8'b0100_0000,
		PH_NL      = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  out_byte;
		logic [15:0] key_length;
		logic [15:0] data_length;
		logic [3:0]  error_code;
		logic [15:0] record_index;
	} out_item_t;

endpackage

### rtl/kvp_in_reg.sv
// Input register stage of the record parser: captures one transaction per cycle
// while the held one moves on. Depends on kvp_pkg for the input item type.
module kvp_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  kvp_pkg::in_item_t  in_data,
	input  logic               advance,
	output logic               valid_s1,
	output kvp_pkg::in_item_t  item_s1
);

	logic valid_q;

	// take a new transaction whenever the held one moves on
	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

endmodule

### rtl/kvp_parse.sv
// Parser state and per-byte next-state logic of the record parser.
// Depends on kvp_pkg for phases, codes, characters and the result type.
module kvp_parse #(
	parameter int LEN_WIDTH = kvp_pkg::LEN_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  kvp_pkg::in_item_t                item,
	input  logic [kvp_pkg::CFG_WIDTH-1:0]    max_key_len,
	input  logic [kvp_pkg::CFG_WIDTH-1:0]    max_data_len,
	output kvp_pkg::out_item_t               res
);

	localparam int CW = (LEN_WIDTH > kvp_pkg::CFG_WIDTH) ? LEN_WIDTH : kvp_pkg::CFG_WIDTH;

	kvp_pkg::phase_t        phase_q, phase_d;
	logic [LEN_WIDTH-1:0]   key_len_q, key_len_d;
	logic [LEN_WIDTH-1:0]   data_len_q, data_len_d;
	logic [LEN_WIDTH-1:0]   bytes_left_q, bytes_left_d;
	logic                   digit_seen_q, digit_seen_d;
	logic [3:0]             sticky_q, sticky_d;
	logic [15:0]            records_q, records_d;

	logic [7:0]             digit;
	logic                   is_digit;
	logic [LEN_WIDTH-1:0]   acc_in;
	logic [LEN_WIDTH+3:0]   acc_wide;
	logic [LEN_WIDTH-1:0]   acc_sat;
	logic [LEN_WIDTH-1:0]   bl_dec;
	logic                   key_over, data_over;
	logic [2:0]             kind;
	logic [7:0]             ob;
	logic [3:0]             err;

	assign digit    = item.in_byte - kvp_pkg::CH_ZERO;
	assign is_digit = digit < kvp_pkg::DEC_BASE;

	// one shared decimal accumulate: acc * 10 + digit, saturating
	assign acc_in   = (phase_q == kvp_pkg::PH_KEYLEN) ? key_len_q : data_len_q;
	assign acc_wide = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
		+ {{LEN_WIDTH{1'b0}}, digit[3:0]};
	assign acc_sat  = (acc_wide[LEN_WIDTH+3:LEN_WIDTH] != 4'd0) ? {LEN_WIDTH{1'b1}}
		: acc_wide[LEN_WIDTH-1:0];

	assign bl_dec    = (bytes_left_q != '0) ? bytes_left_q - LEN_WIDTH'(1) : bytes_left_q;
	assign key_over  = CW'(key_len_q) > CW'(max_key_len);
	assign data_over = CW'(data_len_q) > CW'(max_data_len);

	always_comb begin
		phase_d      = phase_q;
		key_len_d    = key_len_q;
		data_len_d   = data_len_q;
		bytes_left_d = bytes_left_q;
		digit_seen_d = digit_seen_q;
		records_d    = records_q;
		kind         = kvp_pkg::KIND_NONE;
		ob           = 8'd0;
		err          = kvp_pkg::ERR_NONE;

		if (sticky_q != kvp_pkg::ERR_NONE) begin
			err = sticky_q;
		end else if (item.stream_end) begin
			if (phase_q == kvp_pkg::PH_NL) begin
				kind      = kvp_pkg::KIND_DONE;
				records_d = records_q + 16'd1;
				phase_d   = kvp_pkg::PH_PLUS;
			end else if (phase_q != kvp_pkg::PH_PLUS) begin
				err = kvp_pkg::ERR_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				kvp_pkg::PH_PLUS: begin
					if (item.in_byte == kvp_pkg::CH_PLUS) begin
						key_len_d    = '0;
						data_len_d   = '0;
						digit_seen_d = 1'b0;
						phase_d      = kvp_pkg::PH_KEYLEN;
					end else begin
						err = kvp_pkg::ERR_NO_PLUS;
					end
				end
				kvp_pkg::PH_KEYLEN: begin
					if (is_digit) begin
						key_len_d    = acc_sat;
						digit_seen_d = 1'b1;
					end else if (item.in_byte == kvp_pkg::CH_COMMA && digit_seen_q) begin
						if (key_len_q == '0) begin
							err = kvp_pkg::ERR_ZERO_KEY;
						end else if (key_over) begin
							err = kvp_pkg::ERR_OVER_MAX;
						end else begin
							digit_seen_d = 1'b0;
							phase_d      = kvp_pkg::PH_DATALEN;
						end
					end else begin
						err = kvp_pkg::ERR_KEY_LEN;
					end
				end
				kvp_pkg::PH_DATALEN: begin
					if (is_digit) begin
						data_len_d   = acc_sat;
						digit_seen_d = 1'b1;
					end else if (item.in_byte == kvp_pkg::CH_COLON && digit_seen_q) begin
						if (data_over) begin
							err = kvp_pkg::ERR_OVER_MAX;
						end else begin
							bytes_left_d = key_len_q;
							phase_d      = kvp_pkg::PH_KEY;
						end
					end else begin
						err = kvp_pkg::ERR_DATA_LEN;
					end
				end
				kvp_pkg::PH_KEY: begin
					kind         = kvp_pkg::KIND_KEY;
					ob           = item.in_byte;
					bytes_left_d = bl_dec;
					if (bl_dec == '0) begin
						phase_d = kvp_pkg::PH_ARROW1;
					end
				end
				kvp_pkg::PH_ARROW1: begin
					if (item.in_byte == kvp_pkg::CH_DASH) begin
						phase_d = kvp_pkg::PH_ARROW2;
					end else begin
						err = kvp_pkg::ERR_NO_ARROW;
					end
				end
				kvp_pkg::PH_ARROW2: begin
					if (item.in_byte == kvp_pkg::CH_GT) begin
						bytes_left_d = data_len_q;
						phase_d = (data_len_q == '0) ? kvp_pkg::PH_NL : kvp_pkg::PH_DATA;
					end else begin
						err = kvp_pkg::ERR_NO_ARROW;
					end
				end
				kvp_pkg::PH_DATA: begin
					kind         = kvp_pkg::KIND_DATA;
					ob           = item.in_byte;
					bytes_left_d = bl_dec;
					if (bl_dec == '0) begin
						phase_d = kvp_pkg::PH_NL;
					end
				end
				kvp_pkg::PH_NL: begin
					if (item.in_byte == kvp_pkg::CH_NL) begin
						kind      = kvp_pkg::KIND_DONE;
						records_d = records_q + 16'd1;
						phase_d   = kvp_pkg::PH_PLUS;
					end else begin
						err = kvp_pkg::ERR_LINE_END;
					end
				end
				default: begin
					phase_d = kvp_pkg::PH_PLUS;
				end
			endcase
		end

		// any fault overrides the kind and drops the byte
		if (err != kvp_pkg::ERR_NONE) begin
			kind = kvp_pkg::KIND_ERROR;
			ob   = 8'd0;
		end
		sticky_d = err;
	end

	assign res.kind         = kind;
	assign res.out_byte     = ob;
	assign res.key_length   = 16'(key_len_d);
	assign res.data_length  = 16'(data_len_d);
	assign res.error_code   = err;
	assign res.record_index = records_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= kvp_pkg::PH_PLUS;
			key_len_q    <= '0;
			data_len_q   <= '0;
			bytes_left_q <= '0;
			digit_seen_q <= 1'b0;
			sticky_q     <= kvp_pkg::ERR_NONE;
			records_q    <= 16'd0;
		end else if (fire) begin
			phase_q      <= phase_d;
			key_len_q    <= key_len_d;
			data_len_q   <= data_len_d;
			bytes_left_q <= bytes_left_d;
			digit_seen_q <= digit_seen_d;
			sticky_q     <= sticky_d;
			records_q    <= records_d;
		end
	end

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q != kvp_pkg::ERR_NONE |=> sticky_q == $past(sticky_q))
		else $error("sticky error changed after being set");

	a_record_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.kind == kvp_pkg::KIND_DONE |=> records_q == $past(records_q) + 16'd1)
		else $error("record counter did not advance on a completed record");

	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> ((res.kind == kvp_pkg::KIND_ERROR) == (res.error_code != kvp_pkg::ERR_NONE)))
		else $error("error kind and error code disagree");

	a_key_pass: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == kvp_pkg::PH_KEY && sticky_q == kvp_pkg::ERR_NONE
		&& !item.stream_end |-> res.kind == kvp_pkg::KIND_KEY && res.out_byte == item.in_byte)
		else $error("key byte not passed through");

endmodule

### rtl/kvp_out_reg.sv
// Result register of the record parser: holds one result until the sink takes it.
// Depends on kvp_pkg for the result item type.
module kvp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  kvp_pkg::out_item_t  res,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output kvp_pkg::out_item_t  out_data
);

	logic valid_q;

	// free when empty or when the held transaction leaves this cycle
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data <= res;
		end
	end

endmodule

### rtl/kv_record_stream_parser.sv
// Parses "+K,D:key->data\n" records one byte per transaction, one result each.
// An item is accepted every cycle when the sink keeps up; its result passes
// through the input register and then the result register behind the parser
// logic before it is offered. The parser state updates once per byte, so the
// single decimal accumulate and phase decode set the one-byte-per-cycle rate.
// Errors stick until reset; limits come from registers 0 (key) and 1 (data).
// Depends on kvp_pkg, kvp_in_reg, kvp_parse and kvp_out_reg.
module kv_record_stream_parser #(
	parameter int LEN_WIDTH = kvp_pkg::LEN_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  kvp_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output kvp_pkg::out_item_t             out_data,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_index,
	input  logic [kvp_pkg::CFG_WIDTH-1:0]  cfg_data
);

	logic                            valid_s1;
	kvp_pkg::in_item_t               item_s1;
	logic                            space;
	logic                            advance;
	kvp_pkg::out_item_t              res;
	logic [kvp_pkg::CFG_WIDTH-1:0]   max_key_q;
	logic [kvp_pkg::CFG_WIDTH-1:0]   max_data_q;

	// advance the held byte when the result register can take its result
	assign advance = valid_s1 && space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_key_q  <= '1;
			max_data_q <= '1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kvp_pkg::REG_MAX_KEY_LEN:  max_key_q  <= cfg_data;
				kvp_pkg::REG_MAX_DATA_LEN: max_data_q <= cfg_data;
				default: ;
			endcase
		end
	end

	kvp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	kvp_parse #(
		.LEN_WIDTH (LEN_WIDTH)
	) u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.item         (item_s1),
		.max_key_len  (max_key_q),
		.max_data_len (max_data_q),
		.res          (res)
	);

	kvp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### tb/kvp_result_checker.sv
`timescale 1ns / 1ps
// Monitor and scoreboard for kv_record_stream_parser: predicts each parser result
// from the accepted input transactions and limit writes, and checks the outputs.
// Depends on kvp_pkg.
module kvp_result_checker
	import kvp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_WIDTH-1:0]  cfg_data,
	output int                    mismatches,
	output int                    results_due
);

	logic [15:0] key_limit;
	logic [15:0] data_limit;
	phase_t      ph;
	logic [15:0] key_len;
	logic [15:0] data_len;
	logic [15:0] bytes_left;
	logic        got_digit;
	logic [3:0]  sticky;
	logic [15:0] done_cnt;

	out_item_t parsed_due[$];

	// Decimal accumulate, saturating at the length register's full scale.
	function automatic logic [15:0] add_digit(logic [15:0] acc, logic [7:0] dig);
		logic [31:0] v;
		v = 32'(acc) * 32'd10 + 32'(dig);
		return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic out_item_t parse_byte(in_item_t it);
		out_item_t  r;
		logic [7:0] dig;
		logic [3:0] err;
		r = '0;
		err = ERR_NONE;
		dig = it.in_byte - CH_ZERO;
		if (sticky != ERR_NONE) begin
			r.kind = KIND_ERROR;
			err = sticky;
		end else if (it.stream_end) begin
			if (ph == PH_NL) begin
				r.kind = KIND_DONE;
				done_cnt++;
				ph = PH_PLUS;
			end else if (ph != PH_PLUS) begin
				err = ERR_TRUNCATED;
			end
		end else begin
			case (ph)
				PH_PLUS: begin
					if (it.in_byte == CH_PLUS) begin
						key_len = '0;
						data_len = '0;
						got_digit = 1'b0;
						ph = PH_KEYLEN;
					end else begin
						err = ERR_NO_PLUS;
					end
				end
				PH_KEYLEN: begin
					if (dig < DEC_BASE) begin
						key_len = add_digit(key_len, dig);
						got_digit = 1'b1;
					end else if (it.in_byte == CH_COMMA && got_digit) begin
						if (key_len == 0)
							err = ERR_ZERO_KEY;
						else if (key_len > key_limit)
							err = ERR_OVER_MAX;
						else begin
							got_digit = 1'b0;
							ph = PH_DATALEN;
						end
					end else begin
						err = ERR_KEY_LEN;
					end
				end
				PH_DATALEN: begin
					if (dig < DEC_BASE) begin
						data_len = add_digit(data_len, dig);
						got_digit = 1'b1;
					end else if (it.in_byte == CH_COLON && got_digit) begin
						if (data_len > data_limit)
							err = ERR_OVER_MAX;
						else begin
							bytes_left = key_len;
							ph = PH_KEY;
						end
					end else begin
						err = ERR_DATA_LEN;
					end
				end
				PH_KEY: begin
					r.kind = KIND_KEY;
					r.out_byte = it.in_byte;
					if (bytes_left > 0)
						bytes_left--;
					if (bytes_left == 0)
						ph = PH_ARROW1;
				end
				PH_ARROW1: begin
					if (it.in_byte == CH_DASH)
						ph = PH_ARROW2;
					else
						err = ERR_NO_ARROW;
				end
				PH_ARROW2: begin
					if (it.in_byte == CH_GT) begin
						bytes_left = data_len;
						ph = (data_len == 0) ? PH_NL : PH_DATA;
					end else begin
						err = ERR_NO_ARROW;
					end
				end
				PH_DATA: begin
					r.kind = KIND_DATA;
					r.out_byte = it.in_byte;
					if (bytes_left > 0)
						bytes_left--;
					if (bytes_left == 0)
						ph = PH_NL;
				end
				PH_NL: begin
					if (it.in_byte == CH_NL) begin
						r.kind = KIND_DONE;
						done_cnt++;
						ph = PH_PLUS;
					end else begin
						err = ERR_LINE_END;
					end
				end
				default: ph = PH_PLUS;
			endcase
		end
		if (err != ERR_NONE) begin
			sticky = err;
			r.kind = KIND_ERROR;
			r.out_byte = '0;
		end
		r.key_length = key_len;
		r.data_length = data_len;
		r.error_code = err;
		r.record_index = done_cnt;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_limit = 16'hFFFF;
			data_limit = 16'hFFFF;
			ph = PH_PLUS;
			key_len = '0;
			data_len = '0;
			bytes_left = '0;
			got_digit = 1'b0;
			sticky = ERR_NONE;
			done_cnt = '0;
			mismatches = 0;
			results_due = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_MAX_KEY_LEN)
					key_limit = cfg_data[15:0];
				else
					data_limit = cfg_data[15:0];
			end
			if (in_valid && in_ready)
				parsed_due.push_back(parse_byte(in_data));
			if (out_valid && out_ready) begin
				if (parsed_due.size() == 0) begin
					$error("result transaction with nothing expected: kind %0d", out_data.kind);
					mismatches++;
				end else begin
					out_item_t want;
					want = parsed_due.pop_front();
					check_field("kind", want.kind, out_data.kind);
					check_field("out_byte", want.out_byte, out_data.out_byte);
					check_field("key_length", want.key_length, out_data.key_length);
					check_field("data_length", want.data_length, out_data.data_length);
					check_field("error_code", want.error_code, out_data.error_code);
					check_field("record_index", want.record_index, out_data.record_index);
				end
			end
			results_due = parsed_due.size();
		end
	end

endmodule

### tb/kv_record_stream_parser_test.sv
`timescale 1ns / 1ps
// Top of the kv_record_stream_parser testbench: clock, reset, record stream
// stimulus, limit writes and sink stalls. Depends on kvp_pkg and kvp_result_checker.
module kv_record_stream_parser_test;
	import kvp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;
	localparam int SETTLE      = 10;

	typedef enum int {RX_FREE, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_wr_en;
	logic                 cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;
	int                   mismatches;
	int                   results_due;

	int       n_sent = 0;
	int       burst_left = 0;
	int       lim_key = 65535;
	int       lim_data = 65535;
	int       hold_req = 0;
	int       hold_done = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	int       tick = 0;
	int       idle_cycles = 0;
	rx_mode_t rx_mode = RX_FREE;

	kv_record_stream_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	kvp_result_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sink: a long hold-off on request, otherwise a stall pattern that changes now and then.
	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 160);
			end
			mode_left--;
			tick++;
			case (rx_mode)
				RX_FREE:   out_ready <= 1'b1;
				RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
				default:   out_ready <= ((tick % 5) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("kv_record_stream_parser_test NOT OK");
				$finish;
			end
		end
	end

	// Offer one transaction; bursts of random length with random gaps between them.
	task automatic send(input logic [7:0] b, input logic end_mark);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{in_byte: b, stream_end: end_mark};
		do @(posedge clk); while (!in_ready);
		n_sent++;
	endtask

	task automatic sender_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Pause the source until every predicted result is out.
	task automatic drain();
		sender_idle();
		while (results_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic idx, input int value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_WIDTH'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_MAX_KEY_LEN)
			lim_key = value;
		else
			lim_data = value;
	endtask

	// Decimal digits, sometimes with leading zeros.
	task automatic send_number(input int value);
		int digs[$];
		int zeros;
		int v;
		v = value;
		zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
		repeat (zeros) send(CH_ZERO, 1'b0);
		do begin
			digs.push_front(v % 10);
			v = v / 10;
		end while (v > 0);
		foreach (digs[i])
			send(CH_ZERO + 8'(digs[i]), 1'b0);
	endtask

	// Whole record; declared lengths beyond full scale saturate in the parser.
	task automatic send_record(input int kl, input int dl);
		int kn;
		int dn;
		kn = (kl > 65535) ? 65535 : kl;
		dn = (dl > 65535) ? 65535 : dl;
		send(CH_PLUS, 1'b0);
		send_number(kl);
		send(CH_COMMA, 1'b0);
		send_number(dl);
		send(CH_COLON, 1'b0);
		repeat (kn) send(8'($urandom_range(0, 255)), 1'b0);
		send(CH_DASH, 1'b0);
		send(CH_GT, 1'b0);
		repeat (dn) send(8'($urandom_range(0, 255)), 1'b0);
		// a stream end may stand in for the final newline
		if ($urandom_range(0, 6) == 0)
			send(8'($urandom_range(0, 255)), 1'b1);
		else
			send(CH_NL, 1'b0);
		if ($urandom_range(0, 9) == 0)
			send(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic run_records(input int target, input bit at_limit);
		int kl;
		int dl;
		int kcap;
		int dcap;
		kcap = (lim_key < 12) ? lim_key : 12;
		dcap = (lim_data < 12) ? lim_data : 12;
		while (n_sent < target) begin
			kl = (at_limit && $urandom_range(0, 3) == 0) ? lim_key : $urandom_range(1, kcap);
			dl = (at_limit && $urandom_range(0, 3) == 0) ? lim_data : $urandom_range(0, dcap);
			send_record(kl, dl);
		end
	endtask

	// Break the stream once; the error then sticks for the rest of the run.
	task automatic break_stream();
		logic [3:0] code;
		logic [7:0] b;
		int         lim;
		code = 4'($urandom_range(ERR_NO_PLUS, ERR_OVER_MAX));
		case (code)
			ERR_NO_PLUS: begin
				b = 8'($urandom_range(0, 255));
				send((b == CH_PLUS) ? CH_DASH : b, 1'b0);
			end
			ERR_KEY_LEN: begin
				send(CH_PLUS, 1'b0);
				if ($urandom_range(0, 1)) begin
					send_number(7);
					send(CH_COLON, 1'b0);
				end else begin
					send(CH_COMMA, 1'b0);
				end
			end
			ERR_ZERO_KEY: begin
				send(CH_PLUS, 1'b0);
				send_number(0);
				send(CH_COMMA, 1'b0);
			end
			ERR_DATA_LEN: begin
				send(CH_PLUS, 1'b0);
				send_number(3);
				send(CH_COMMA, 1'b0);
				if ($urandom_range(0, 1)) begin
					send_number(2);
					send(CH_DASH, 1'b0);
				end else begin
					send(CH_COLON, 1'b0);
				end
			end
			ERR_NO_ARROW: begin
				send(CH_PLUS, 1'b0);
				send_number(1);
				send(CH_COMMA, 1'b0);
				send_number(0);
				send(CH_COLON, 1'b0);
				send(8'($urandom_range(0, 255)), 1'b0);
				if ($urandom_range(0, 1)) begin
					send(CH_GT, 1'b0);
				end else begin
					send(CH_DASH, 1'b0);
					send(CH_DASH, 1'b0);
				end
			end
			ERR_LINE_END: begin
				send(CH_PLUS, 1'b0);
				send_number(1);
				send(CH_COMMA, 1'b0);
				send_number(1);
				send(CH_COLON, 1'b0);
				send(8'($urandom_range(0, 255)), 1'b0);
				send(CH_DASH, 1'b0);
				send(CH_GT, 1'b0);
				send(8'($urandom_range(0, 255)), 1'b0);
				send(CH_PLUS, 1'b0);
			end
			ERR_TRUNCATED: begin
				send(CH_PLUS, 1'b0);
				// key length declared past full scale, so it saturates
				send_number(70000);
				if ($urandom_range(0, 1)) begin
					send(CH_COMMA, 1'b0);
					send_number(1);
				end
				send(8'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				lim = $urandom_range(1, 20);
				if ($urandom_range(0, 1)) begin
					write_limit(REG_MAX_KEY_LEN, lim);
					send(CH_PLUS, 1'b0);
					send_number(lim + 1);
					send(CH_COMMA, 1'b0);
				end else begin
					write_limit(REG_MAX_DATA_LEN, lim);
					send(CH_PLUS, 1'b0);
					send_number(1);
					send(CH_COMMA, 1'b0);
					send_number(lim + 1);
					send(CH_COLON, 1'b0);
				end
			end
		endcase
		repeat (20) send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_MAX_KEY_LEN;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// stream end before any record, then a key-only record with empty data
		send(8'hFF, 1'b1);
		send(CH_PLUS, 1'b0);
		send(CH_ZERO + 8'd1, 1'b0);
		send(CH_COMMA, 1'b0);
		send(CH_ZERO, 1'b0);
		send(CH_COLON, 1'b0);
		send(8'hFF, 1'b0);
		send(CH_DASH, 1'b0);
		send(CH_GT, 1'b0);
		send(CH_NL, 1'b0);
		// leading zero in the key length, stream end in place of the newline
		send(CH_PLUS, 1'b0);
		send(CH_ZERO, 1'b0);
		send(CH_ZERO + 8'd1, 1'b0);
		send(CH_COMMA, 1'b0);
		send(CH_ZERO + 8'd2, 1'b0);
		send(CH_COLON, 1'b0);
		send(8'h00, 1'b0);
		send(CH_DASH, 1'b0);
		send(CH_GT, 1'b0);
		send(8'hFF, 1'b0);
		send(8'h00, 1'b0);
		send(8'h00, 1'b1);

		run_records(n_sent + 400, 1'b0);

		drain();
		write_limit(REG_MAX_KEY_LEN, 1);
		write_limit(REG_MAX_DATA_LEN, 0);
		run_records(n_sent + 150, 1'b1);

		drain();
		write_limit(REG_MAX_KEY_LEN, $urandom_range(1, 40));
		write_limit(REG_MAX_DATA_LEN, $urandom_range(0, 40));
		hold_req++;
		run_records(n_sent + 450, 1'b1);

		drain();
		write_limit(REG_MAX_KEY_LEN, 65535);
		write_limit(REG_MAX_DATA_LEN, 65535);
		run_records(n_sent + 200, 1'b0);
		hold_req++;
		run_records(n_sent + 200, 1'b0);

		drain();
		break_stream();

		drain();
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("kv_record_stream_parser_test OK");
		else
			$display("kv_record_stream_parser_test NOT OK");
		$finish;
	end

endmodule
